// ===== sv/rssp_pkg.sv =====
// ============================================================================
// rssp_pkg
// Shared types and constants of the range sensor smoothing block.
// ============================================================================
package rssp_pkg;

    // channel numbers
    localparam int NUM_CH = 13;
    localparam logic [3:0] CH_USS_FL      = 4'd0;
    localparam logic [3:0] CH_USS_FR      = 4'd1;
    localparam logic [3:0] CH_USS_RL      = 4'd2;
    localparam logic [3:0] CH_USS_RR      = 4'd3;
    localparam logic [3:0] CH_IR_FL_LONG  = 4'd4;
    localparam logic [3:0] CH_IR_FL_SHORT = 4'd5;
    localparam logic [3:0] CH_IR_FC_LONG  = 4'd6;
    localparam logic [3:0] CH_IR_FC_SHORT = 4'd7;
    localparam logic [3:0] CH_IR_FR_LONG  = 4'd8;
    localparam logic [3:0] CH_IR_FR_SHORT = 4'd9;
    localparam logic [3:0] CH_IR_RC       = 4'd10;
    localparam logic [3:0] CH_IR_RL       = 4'd11;
    localparam logic [3:0] CH_IR_RR       = 4'd12;

    // detection points
    localparam int NUM_PTS = 10;
    localparam logic [3:0] PT_USS_FL = 4'd0;
    localparam logic [3:0] PT_USS_FR = 4'd1;
    localparam logic [3:0] PT_USS_RL = 4'd2;
    localparam logic [3:0] PT_USS_RR = 4'd3;
    localparam logic [3:0] PT_IR_FL  = 4'd4;
    localparam logic [3:0] PT_IR_FR  = 4'd5;
    localparam logic [3:0] PT_IR_FC  = 4'd6;
    localparam logic [3:0] PT_IR_RC  = 4'd7;
    localparam logic [3:0] PT_IR_RL  = 4'd8;
    localparam logic [3:0] PT_IR_RR  = 4'd9;
    localparam logic [3:0] PT_LAST   = PT_IR_RR;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FILTER_STRENGTH = 2'd0,
        CFG_IR_SCALE        = 2'd1,
        CFG_HOLD_TIME       = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] FILTER_STRENGTH_RST = 16'd45875;
    localparam logic [15:0] IR_SCALE_RST        = 16'd21299;
    localparam logic [31:0] HOLD_TIME_RST       = 32'd800000;

    // Q0.16 rotation coefficients (15 deg)
    localparam logic [15:0] COS15_Q16 = 16'd63303;
    localparam logic [15:0] SIN15_Q16 = 16'd16962;

    // gate thresholds, whole mm
    localparam int THR_50_MM    = 50;
    localparam int THR_150_MM   = 150;
    localparam int THR_200_MM   = 200;
    localparam int THR_250_MM   = 250;
    localparam int THR_300_MM   = 300;
    localparam int THR_600_MM   = 600;
    localparam int THR_1500_MM  = 1500;
    localparam int MEAN_RESET_MM = 9999;

    // coordinates, mm
    localparam logic [15:0] C_FAR     = 16'd9999;
    localparam logic [15:0] C_NFAR    = 16'hD8F1;  // -9999
    localparam logic [15:0] C_480     = 16'd480;
    localparam logic [15:0] C_485     = 16'd485;
    localparam logic [15:0] C_450     = 16'd450;
    localparam logic [15:0] C_110     = 16'd110;
    localparam logic [15:0] C_N110    = 16'hFF92;  // -110
    localparam logic [15:0] C_60      = 16'd60;
    localparam logic [15:0] C_N60     = 16'hFFC4;  // -60
    localparam logic [15:0] C_62      = 16'd62;
    localparam logic [15:0] C_56      = 16'd56;
    localparam logic [15:0] C_150     = 16'd150;
    localparam logic [15:0] C_N150    = 16'hFF6A;  // -150
    localparam logic [15:0] C_65      = 16'd65;
    localparam logic [15:0] C_68      = 16'd68;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_MUL     = 3'd1,
        S_ACC     = 3'd2,
        S_EMIT_RD = 3'd3,
        S_EMIT_LD = 3'd4,
        S_CALC    = 3'd5,
        S_DRAIN   = 3'd6
    } t_state;

    typedef struct packed {
        logic       take;      // latch request, read channel mean
        logic       mul;       // mean update products
        logic       mean_wr;   // mean update write back
        logic       pt_rd;     // read point store
        logic       calc;      // issue one point recompute
        logic [3:0] pt_idx;
        logic       out_load;  // load output register
        logic [3:0] out_idx;
    } t_ctl_cmd;

    typedef struct packed {
        logic ch_ok;      // selector names a channel
        logic emit;       // current request emits the point set
        logic out_free;   // output register can take a point
        logic calc_busy;  // recompute pipeline holds work
    } t_dp_sts;

endpackage

// ===== sv/rssp_in_if.sv =====
// ============================================================================
// rssp_in_if
// Sample request channel: valid/ready with one distance sample.
// ============================================================================
interface rssp_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  sensor_select;
    logic [15:0] distance_cm;
    logic [31:0] elapsed_us;

    modport source (output valid, output sensor_select, output distance_cm,
                    output elapsed_us, input ready);
    modport sink   (input valid, input sensor_select, input distance_cm,
                    input elapsed_us, output ready);
endinterface

// ===== sv/rssp_out_if.sv =====
// ============================================================================
// rssp_out_if
// Point channel: valid/ready with one detection point.
// ============================================================================
interface rssp_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         point_index;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic               last;

    modport source (output valid, output point_index, output x_mm, output y_mm,
                    output last, input ready);
    modport sink   (input valid, input point_index, input x_mm, input y_mm,
                    input last, output ready);
endinterface

// ===== sv/rssp_ctrl.sv =====
// ============================================================================
// rssp_ctrl
// Sequencer: mean update, point set emission, point recompute.
// ============================================================================
module rssp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rssp_pkg::t_dp_sts  i_sts,
    output rssp_pkg::t_ctl_cmd o_cmd
);

    rssp_pkg::t_state r_state, n_state;
    logic [3:0]       r_idx, n_idx;
    logic             accept;

    assign o_in_ready = (r_state == rssp_pkg::S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rssp_pkg::S_IDLE;
            r_idx   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            rssp_pkg::S_IDLE: begin
                n_idx = 4'd0;
                if (accept && i_sts.ch_ok) begin
                    n_state = rssp_pkg::S_MUL;
                end
            end
            rssp_pkg::S_MUL: begin
                n_state = rssp_pkg::S_ACC;
            end
            rssp_pkg::S_ACC: begin
                n_idx   = 4'd0;
                n_state = i_sts.emit ? rssp_pkg::S_EMIT_RD : rssp_pkg::S_CALC;
            end
            rssp_pkg::S_EMIT_RD: begin
                n_state = rssp_pkg::S_EMIT_LD;
            end
            rssp_pkg::S_EMIT_LD: begin
                if (i_sts.out_free) begin
                    if (r_idx == rssp_pkg::PT_LAST) begin
                        n_idx   = 4'd0;
                        n_state = rssp_pkg::S_CALC;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            rssp_pkg::S_CALC: begin
                if (r_idx == rssp_pkg::PT_LAST) begin
                    n_idx   = 4'd0;
                    n_state = rssp_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            rssp_pkg::S_DRAIN: begin
                if (!i_sts.calc_busy) begin
                    n_state = rssp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rssp_pkg::S_IDLE;
                n_idx   = 4'd0;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            rssp_pkg::S_IDLE: begin
                o_cmd.take = accept & i_sts.ch_ok;
            end
            rssp_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            rssp_pkg::S_ACC: begin
                o_cmd.mean_wr = 1'b1;
            end
            rssp_pkg::S_EMIT_RD: begin
                o_cmd.pt_rd  = 1'b1;
                o_cmd.pt_idx = r_idx;
            end
            rssp_pkg::S_EMIT_LD: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_idx  = r_idx;
                if (i_sts.out_free && (r_idx != rssp_pkg::PT_LAST)) begin
                    o_cmd.pt_rd  = 1'b1;
                    o_cmd.pt_idx = r_idx + 4'd1;
                end
            end
            rssp_pkg::S_CALC: begin
                o_cmd.calc   = 1'b1;
                o_cmd.pt_idx = r_idx;
            end
            rssp_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register loaded while occupied");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rssp_pkg::S_IDLE) |-> !i_sts.calc_busy)
        else $error("new request possible while recompute in flight");

    a_wr_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mean_wr |-> $past(o_cmd.mul))
        else $error("mean write without product step");

    a_last_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && (o_cmd.out_idx == rssp_pkg::PT_LAST))
            |=> (r_state == rssp_pkg::S_CALC))
        else $error("recompute did not follow the last point");

endmodule

// ===== sv/rssp_dpath.sv =====
// ============================================================================
// rssp_dpath
// Datapath: config registers, mean store and update, point recompute
// pipeline, point store and output register.
// ============================================================================
module rssp_dpath #(
    parameter int MEAN_FRAC_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic [3:0]         i_sensor_select,
    input  logic [15:0]        i_distance_cm,
    input  logic [31:0]        i_elapsed_us,
    input  rssp_pkg::t_ctl_cmd i_cmd,
    output rssp_pkg::t_dp_sts  o_sts,
    rssp_out_if.source         o_out
);

    localparam int F  = MEAN_FRAC_BITS;
    localparam int MW = 16 + F;

    localparam logic [MW-1:0] MEAN_RST = MW'(rssp_pkg::MEAN_RESET_MM) << F;
    localparam logic [MW-1:0] TH_50    = MW'(rssp_pkg::THR_50_MM) << F;
    localparam logic [MW-1:0] TH_150   = MW'(rssp_pkg::THR_150_MM) << F;
    localparam logic [MW-1:0] TH_200   = MW'(rssp_pkg::THR_200_MM) << F;
    localparam logic [MW-1:0] TH_250   = MW'(rssp_pkg::THR_250_MM) << F;
    localparam logic [MW-1:0] TH_300   = MW'(rssp_pkg::THR_300_MM) << F;
    localparam logic [MW-1:0] TH_600   = MW'(rssp_pkg::THR_600_MM) << F;
    localparam logic [MW-1:0] TH_1500  = MW'(rssp_pkg::THR_1500_MM) << F;

    // short (or only) channel feeding a point
    function automatic logic [3:0] f_prim_ch(input logic [3:0] p);
        logic [3:0] ch;
        case (p)
            rssp_pkg::PT_USS_FL: ch = rssp_pkg::CH_USS_FL;
            rssp_pkg::PT_USS_FR: ch = rssp_pkg::CH_USS_FR;
            rssp_pkg::PT_USS_RL: ch = rssp_pkg::CH_USS_RL;
            rssp_pkg::PT_USS_RR: ch = rssp_pkg::CH_USS_RR;
            rssp_pkg::PT_IR_FL:  ch = rssp_pkg::CH_IR_FL_SHORT;
            rssp_pkg::PT_IR_FR:  ch = rssp_pkg::CH_IR_FR_SHORT;
            rssp_pkg::PT_IR_FC:  ch = rssp_pkg::CH_IR_FC_SHORT;
            rssp_pkg::PT_IR_RC:  ch = rssp_pkg::CH_IR_RC;
            rssp_pkg::PT_IR_RL:  ch = rssp_pkg::CH_IR_RL;
            rssp_pkg::PT_IR_RR:  ch = rssp_pkg::CH_IR_RR;
            default:             ch = rssp_pkg::CH_USS_FL;
        endcase
        return ch;
    endfunction

    // long-range channel, front IR points only
    function automatic logic [3:0] f_sec_ch(input logic [3:0] p);
        logic [3:0] ch;
        case (p)
            rssp_pkg::PT_IR_FL: ch = rssp_pkg::CH_IR_FL_LONG;
            rssp_pkg::PT_IR_FR: ch = rssp_pkg::CH_IR_FR_LONG;
            rssp_pkg::PT_IR_FC: ch = rssp_pkg::CH_IR_FC_LONG;
            default:            ch = rssp_pkg::CH_USS_FL;
        endcase
        return ch;
    endfunction

    // ---------------- config ----------------
    logic [15:0] r_strength;
    logic [15:0] r_ir_scale;
    logic [31:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= rssp_pkg::FILTER_STRENGTH_RST;
            r_ir_scale <= rssp_pkg::IR_SCALE_RST;
            r_hold     <= rssp_pkg::HOLD_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rssp_pkg::CFG_FILTER_STRENGTH: r_strength <= i_cfg_data[15:0];
                rssp_pkg::CFG_IR_SCALE:        r_ir_scale <= i_cfg_data[15:0];
                rssp_pkg::CFG_HOLD_TIME:       r_hold     <= i_cfg_data;
                default:                       r_hold     <= r_hold;
            endcase
        end
    end

    // ---------------- request latch ----------------
    logic [3:0]    r_ch;
    logic [MW-1:0] r_sample;
    logic          r_emit;
    logic [19:0]   d10;

    assign d10 = 20'(i_distance_cm) * 20'd10;  // Q16.4 mm

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ch     <= i_sensor_select;
            r_sample <= MW'((28'(d10) << F) >> 4);
            r_emit   <= (i_sensor_select == rssp_pkg::CH_IR_RR)
                        && (i_elapsed_us >= r_hold);
        end
    end

    // ---------------- mean store ----------------
    logic [MW-1:0] r_mean_mem [rssp_pkg::NUM_CH];
    logic          r_mean_vld [rssp_pkg::NUM_CH];
    logic [MW-1:0] r_mean_a, r_mean_b;
    logic          r_mean_a_vld, r_mean_b_vld;
    logic [3:0]    addr_a, addr_b;
    logic [MW-1:0] mean_a, mean_b;
    logic [MW-1:0] mean_new;

    assign addr_a = i_cmd.take ? i_sensor_select : f_prim_ch(i_cmd.pt_idx);
    assign addr_b = f_sec_ch(i_cmd.pt_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_wr) begin
            r_mean_mem[r_ch] <= mean_new;
        end
        if (i_cmd.take || i_cmd.calc) begin
            r_mean_a     <= r_mean_mem[addr_a];
            r_mean_a_vld <= r_mean_vld[addr_a];
        end
        if (i_cmd.calc) begin
            r_mean_b     <= r_mean_mem[addr_b];
            r_mean_b_vld <= r_mean_vld[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rssp_pkg::NUM_CH; i++) begin
                r_mean_vld[i] <= 1'b0;
            end
        end else if (i_cmd.mean_wr) begin
            r_mean_vld[r_ch] <= 1'b1;
        end
    end

    assign mean_a = r_mean_a_vld ? r_mean_a : MEAN_RST;
    assign mean_b = r_mean_b_vld ? r_mean_b : MEAN_RST;

    // ---------------- mean update ----------------
    logic [MW+15:0] r_prod_old;
    logic [MW+16:0] r_prod_new;
    logic [16:0]    w_new;
    logic [MW+17:0] acc;

    assign w_new = 17'h10000 - {1'b0, r_strength};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_old <= (MW+16)'(r_strength) * (MW+16)'(mean_a);
            r_prod_new <= (MW+17)'(w_new) * (MW+17)'(r_sample);
        end
    end

    assign acc      = (MW+18)'(r_prod_old) + (MW+18)'(r_prod_new) + (MW+18)'(32768);
    assign mean_new = acc[16 +: MW];

    // ---------------- recompute stage 1: gates and products ----------------
    logic          r_c0_vld;
    logic [3:0]    r_c0_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_vld <= 1'b0;
        end else begin
            r_c0_vld <= i_cmd.calc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_c0_idx <= i_cmd.pt_idx;
        end
    end

    logic a_le50, a_le200, a_le250, a_lt1500, a_gt150, a_gt300;
    logic b_gt200, b_lt600;
    logic d_wr, d_use_l, d_uss, d_front, d_left, d_neg;
    logic [15:0] d_xbase, d_ybase;
    logic d_xlin, d_ylin, d_xneg, d_yneg;

    assign a_le50   = mean_a <= TH_50;
    assign a_le200  = mean_a <= TH_200;
    assign a_le250  = mean_a <= TH_250;
    assign a_lt1500 = mean_a <  TH_1500;
    assign a_gt150  = mean_a >  TH_150;
    assign a_gt300  = mean_a >  TH_300;
    assign b_gt200  = mean_b >  TH_200;
    assign b_lt600  = mean_b <  TH_600;

    assign d_front = (r_c0_idx == rssp_pkg::PT_USS_FL) || (r_c0_idx == rssp_pkg::PT_USS_FR);
    assign d_left  = (r_c0_idx == rssp_pkg::PT_USS_FL) || (r_c0_idx == rssp_pkg::PT_USS_RL);
    assign d_neg   = (r_c0_idx == rssp_pkg::PT_IR_FR);

    always_comb begin
        d_wr    = 1'b0;
        d_use_l = 1'b0;
        d_uss   = 1'b0;
        d_xbase = '0;
        d_ybase = '0;
        d_xlin  = 1'b0;
        d_ylin  = 1'b0;
        d_xneg  = 1'b0;
        d_yneg  = 1'b0;
        case (r_c0_idx)
            rssp_pkg::PT_USS_FL, rssp_pkg::PT_USS_FR,
            rssp_pkg::PT_USS_RL, rssp_pkg::PT_USS_RR: begin
                d_wr  = 1'b1;
                d_uss = 1'b1;
                if (a_le200) begin
                    d_xbase = d_front ? rssp_pkg::C_480 : rssp_pkg::C_N110;
                    d_ybase = d_left ? rssp_pkg::C_60 : rssp_pkg::C_N60;
                end else if (a_lt1500) begin
                    d_xlin  = 1'b1;
                    d_ylin  = 1'b1;
                    d_xbase = d_front ? rssp_pkg::C_485 : rssp_pkg::C_110;
                    d_ybase = d_front ? rssp_pkg::C_62 : rssp_pkg::C_56;
                    d_xneg  = !d_front;
                    d_yneg  = !d_left;
                end else begin
                    d_xbase = d_front ? rssp_pkg::C_FAR : rssp_pkg::C_NFAR;
                    d_ybase = rssp_pkg::C_FAR;
                end
            end
            rssp_pkg::PT_IR_FL, rssp_pkg::PT_IR_FR: begin
                if (a_le50) begin
                    d_wr    = 1'b1;
                    d_xbase = rssp_pkg::C_480;
                    d_ybase = d_neg ? rssp_pkg::C_N150 : rssp_pkg::C_150;
                end else if (a_le250) begin
                    d_wr    = 1'b1;
                    d_xbase = rssp_pkg::C_450;
                    d_ybase = rssp_pkg::C_150;
                    d_ylin  = 1'b1;
                    d_yneg  = d_neg;
                end else if (b_gt200 && b_lt600) begin
                    d_wr    = 1'b1;
                    d_use_l = 1'b1;
                    d_xbase = rssp_pkg::C_450;
                    d_ybase = rssp_pkg::C_150;
                    d_ylin  = 1'b1;
                    d_yneg  = d_neg;
                end else if (a_gt300 && !b_lt600) begin
                    d_wr    = 1'b1;
                    d_xbase = rssp_pkg::C_480;
                    d_ybase = rssp_pkg::C_FAR;
                end
                // no rule: point keeps its value
            end
            rssp_pkg::PT_IR_FC: begin
                if (a_le50) begin
                    d_wr    = 1'b1;
                    d_xbase = rssp_pkg::C_480;
                end else if (a_le250) begin
                    d_wr    = 1'b1;
                    d_xbase = rssp_pkg::C_480;
                    d_xlin  = 1'b1;
                end else if (b_gt200 && b_lt600) begin
                    d_wr    = 1'b1;
                    d_use_l = 1'b1;
                    d_xbase = rssp_pkg::C_480;
                    d_xlin  = 1'b1;
                end else if (a_gt150 && !b_lt600) begin
                    d_wr    = 1'b1;
                    d_ybase = rssp_pkg::C_FAR;
                end
            end
            rssp_pkg::PT_IR_RC: begin
                d_wr = 1'b1;
                if (a_le50) begin
                    d_xbase = rssp_pkg::C_N110;
                end else if (a_le250) begin
                    d_xbase = rssp_pkg::C_110;
                    d_xlin  = 1'b1;
                    d_xneg  = 1'b1;
                end else begin
                    d_ybase = rssp_pkg::C_FAR;
                end
            end
            rssp_pkg::PT_IR_RL, rssp_pkg::PT_IR_RR: begin
                d_wr = 1'b1;
                if (a_le50) begin
                    d_xbase = rssp_pkg::C_65;
                    d_ybase = (r_c0_idx == rssp_pkg::PT_IR_RR) ? rssp_pkg::C_N150
                                                               : rssp_pkg::C_150;
                end else if (a_le250) begin
                    d_xbase = rssp_pkg::C_68;
                    d_ybase = rssp_pkg::C_150;
                    d_ylin  = 1'b1;
                    d_yneg  = (r_c0_idx == rssp_pkg::PT_IR_RR);
                end else begin
                    d_xbase = rssp_pkg::C_65;
                    d_ybase = rssp_pkg::C_FAR;
                end
            end
            default: begin
                d_wr = 1'b0;
            end
        endcase
    end

    logic [MW-1:0]  op;
    logic [15:0]    cx, cy;
    logic [MW+15:0] prod_x, prod_y;
    logic [15:0]    add_x, add_y;

    assign op     = d_use_l ? mean_b : mean_a;
    assign cx     = d_uss ? rssp_pkg::COS15_Q16 : r_ir_scale;
    assign cy     = d_uss ? rssp_pkg::SIN15_Q16 : r_ir_scale;
    assign prod_x = (MW+16)'(op) * (MW+16)'(cx);
    assign prod_y = (MW+16)'(op) * (MW+16)'(cy);
    // Q0.16 coefficients for ultrasonic, Q2.14 scale for infrared
    assign add_x  = d_uss ? prod_x[16+F +: 16] : prod_x[14+F +: 16];
    assign add_y  = d_uss ? prod_y[16+F +: 16] : prod_y[14+F +: 16];

    // ---------------- recompute stage 2: add, sign, write ----------------
    logic        r_c1_vld;
    logic [3:0]  r_c1_idx;
    logic        r_c1_wr;
    logic [15:0] r_c1_xbase, r_c1_ybase, r_c1_xadd, r_c1_yadd;
    logic        r_c1_xneg, r_c1_yneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else begin
            r_c1_vld <= r_c0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c0_vld) begin
            r_c1_idx   <= r_c0_idx;
            r_c1_wr    <= d_wr;
            r_c1_xbase <= d_xbase;
            r_c1_ybase <= d_ybase;
            r_c1_xadd  <= d_xlin ? add_x : 16'd0;
            r_c1_yadd  <= d_ylin ? add_y : 16'd0;
            r_c1_xneg  <= d_xneg;
            r_c1_yneg  <= d_yneg;
        end
    end

    logic [15:0] x_sum, y_sum, x_val, y_val;

    assign x_sum = r_c1_xbase + r_c1_xadd;
    assign y_sum = r_c1_ybase + r_c1_yadd;
    assign x_val = r_c1_xneg ? (~x_sum + 16'd1) : x_sum;
    assign y_val = r_c1_yneg ? (~y_sum + 16'd1) : y_sum;

    // ---------------- point store ----------------
    logic [15:0] r_px [rssp_pkg::NUM_PTS];
    logic [15:0] r_py [rssp_pkg::NUM_PTS];
    logic        r_pt_vld [rssp_pkg::NUM_PTS];
    logic [15:0] r_pt_rd_x, r_pt_rd_y;
    logic        r_pt_rd_v;

    always_ff @(posedge i_clk) begin
        if (r_c1_vld && r_c1_wr) begin
            r_px[r_c1_idx] <= x_val;
            r_py[r_c1_idx] <= y_val;
        end
        if (i_cmd.pt_rd) begin
            r_pt_rd_x <= r_px[i_cmd.pt_idx];
            r_pt_rd_y <= r_py[i_cmd.pt_idx];
            r_pt_rd_v <= r_pt_vld[i_cmd.pt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rssp_pkg::NUM_PTS; i++) begin
                r_pt_vld[i] <= 1'b0;
            end
        end else if (r_c1_vld && r_c1_wr) begin
            r_pt_vld[r_c1_idx] <= 1'b1;
        end
    end

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic [3:0]  r_out_idx;
    logic [15:0] r_out_x, r_out_y;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= i_cmd.out_idx;
            r_out_x    <= r_pt_rd_v ? r_pt_rd_x : 16'd0;
            r_out_y    <= r_pt_rd_v ? r_pt_rd_y : 16'd0;
            r_out_last <= (i_cmd.out_idx == rssp_pkg::PT_LAST);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_index = r_out_idx;
    assign o_out.x_mm        = signed'(r_out_x);
    assign o_out.y_mm        = signed'(r_out_y);
    assign o_out.last        = r_out_last;

    // ---------------- status ----------------
    assign o_sts.ch_ok     = i_sensor_select < 4'(rssp_pkg::NUM_CH);
    assign o_sts.emit      = r_emit;
    assign o_sts.out_free  = !r_out_valid || o_out.ready;
    assign o_sts.calc_busy = r_c0_vld || r_c1_vld;

endmodule

// ===== sv/range_sensor_smoothing_to_points_top.sv =====
// ============================================================================
// range_sensor_smoothing_to_points_top
// Range sensor smoothing and detection point generation.
// ============================================================================
// Each request carries one distance sample (cm, Q12.4) from one of 13 range
// channels. The sample is scaled to mm and folded into that channel's
// exponential mean (weight filter_strength on the old mean, rounded), then
// all ten vehicle-frame detection points are recomputed from the means by
// range-gated rules; a front IR point whose rules all miss keeps its value.
// A rear-right IR request whose elapsed_us has reached hold_time_us first
// emits the ten points as they stood before this request (point 0 first,
// last set on point 9), then the recompute runs. Means start at 9999 mm and
// points at zero. A request without emission is accepted, runs the mean
// update (products, then write back), issues one point per cycle into the
// recompute pipe (gates and products, then add, sign and write) and waits
// for it to drain; an emitting request first moves the points from the
// point store to the output register, one point a cycle while the point
// channel takes them. A selector above 12 is taken and changes nothing.
// The last emitted point may still wait in the output register while the
// next request is taken. Configuration writes (index 0 filter_strength, 1
// ir_scale, 2 hold_time_us, others ignored) are meant for idle periods only.
// ============================================================================
module range_sensor_smoothing_to_points_top #(
    parameter int MEAN_FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    rssp_in_if.sink     i_sample,
    rssp_out_if.source  o_point
);

    rssp_pkg::t_ctl_cmd cmd;
    rssp_pkg::t_dp_sts  sts;
    logic               in_ready;

    assign i_sample.ready = in_ready;

    // sequencer: owns request acceptance and step order
    rssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: means, recompute pipe, point store, output register
    rssp_dpath #(
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_sensor_select (i_sample.sensor_select),
        .i_distance_cm   (i_sample.distance_cm),
        .i_elapsed_us    (i_sample.elapsed_us),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out           (o_point)
    );

endmodule
